/* rtl/scara_inverse_kinematics_core_assert.svh */
// Assertion macros for the SCARA inverse kinematics core.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef SCARA_INVERSE_KINEMATICS_CORE_ASSERT_SVH
`define SCARA_INVERSE_KINEMATICS_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SIK_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scara ik: same-cycle check failed");
// next-cycle implication
`define SIK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scara ik: next-cycle check failed");
`else
`define SIK_ASSERT_IMPLY(lbl, ante, cons)
`define SIK_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/scara_ik_pkg.sv */
// Shared types and constants for the SCARA inverse kinematics core.
// No dependencies.
package scara_ik_pkg;

    // internal angle: 1/16384 degree
    localparam int ZW = 25;
    localparam logic signed [ZW-1:0] DEG180_INT = 25'sd2949120;

    localparam int ATAN_LEN = 24;
    localparam logic [19:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        20'd737280, 20'd435242, 20'd229970, 20'd116736, 20'd58595, 20'd29326,
        20'd14667, 20'd7334, 20'd3667, 20'd1833, 20'd917, 20'd458,
        20'd229, 20'd115, 20'd57, 20'd29, 20'd14, 20'd7,
        20'd4, 20'd2, 20'd1, 20'd0, 20'd0, 20'd0
    };

    localparam int PRESCALE_SH = 16;
    localparam int CORDIC_GUARD = PRESCALE_SH + 3;

    // integer root: radicand below 2^58, first trial bit 2^56
    localparam int ISQ_STEPS = 29;
    localparam int SQW = 60;

    localparam int NUMW = 31;   // acos numerator
    localparam int DENW = 56;   // acos squared denominator

    localparam int IW = 28;     // angle sums, internal units
    localparam int OW = 21;     // rounded joint angles
    localparam int SLW = 17;    // slide value
    localparam int SCW = 22;    // score terms
    localparam int ROUND_SH = 8;
    localparam logic signed [IW-1:0] ROUND_BIAS = 28'sd128;
    localparam logic signed [OW-1:0] DEG180_OUT = 21'sd11520;
    localparam logic signed [OW-1:0] DEG360_OUT = 21'sd23040;

    // configuration register indexes
    localparam logic [2:0] REG_UPPER_LINK  = 3'd0;
    localparam logic [2:0] REG_LOWER_LINK  = 3'd1;
    localparam logic [2:0] REG_HEIGHT_OFS  = 3'd2;
    localparam logic [2:0] REG_J1_LIMIT    = 3'd3;
    localparam logic [2:0] REG_J2_LIMIT    = 3'd4;
    localparam logic [2:0] REG_SLIDE_LOW   = 3'd5;
    localparam logic [2:0] REG_SLIDE_HIGH  = 3'd6;
    localparam logic [2:0] REG_J4_LIMIT    = 3'd7;

    // per-pose data carried alongside the arithmetic
    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] phi;
        logic signed [14:0] cur_j1;
        logic signed [14:0] cur_j2;
        logic signed [13:0] cur_slide;
        logic signed [14:0] cur_j4;
    } side_t;

    typedef struct packed {
        logic in_range;
        logic r2_nz;
    } reach_flags_t;

    typedef struct packed {
        logic signed [OW-1:0]  j1;
        logic signed [OW-1:0]  j2;
        logic signed [SLW-1:0] slide;
        logic signed [OW-1:0]  j4;
    } sol_t;

endpackage

/* rtl/scara_ik_cordic_cell.sv */
// One CORDIC vectoring step, registered.
// Depends on scara_ik_pkg (angle table).
module scara_ik_cordic_cell
    import scara_ik_pkg::*;
#(
    parameter int W    = 35,
    parameter int STEP = 0
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    input  logic signed [ZW-1:0] z_in,
    input  logic                 zero_in,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out,
    output logic                 zero_out
);

    localparam logic signed [ZW-1:0] STEP_ANGLE = ZW'(ATAN_TAB[STEP]);

    logic signed [W-1:0]  xs, ys;
    logic signed [W-1:0]  x_next, y_next, x_reg, y_reg;
    logic signed [ZW-1:0] z_next, z_reg;
    logic                 zero_reg;

    always_comb
    begin
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        if (y_in > 0)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + STEP_ANGLE;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - STEP_ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= zero_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign zero_out = zero_reg;

endmodule

/* rtl/scara_ik_isqrt_cell.sv */
// One step of the bitwise integer square root, registered.
// Depends on scara_ik_pkg.
module scara_ik_isqrt_cell
    import scara_ik_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic           clk,
    input  logic           en,
    input  logic [SQW-1:0] v_in,
    input  logic [SQW-1:0] r_in,
    output logic [SQW-1:0] v_out,
    output logic [SQW-1:0] r_out
);

    localparam int BIT_SH = 2 * (ISQ_STEPS - 1 - K);
    localparam logic [SQW-1:0] BIT_VAL = SQW'(1) << BIT_SH;

    logic [SQW-1:0] trial, v_next, r_next, v_reg, r_reg;

    always_comb
    begin
        trial = r_in + BIT_VAL;
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + BIT_VAL;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;

endmodule

/* rtl/scara_ik_atan2.sv */
// Pipelined atan2: quadrant fold and prescale, then a row of CORDIC cells.
// Depends on scara_ik_pkg and scara_ik_cordic_cell.
module scara_ik_atan2
    import scara_ik_pkg::*;
#(
    parameter int WIN   = 16,
    parameter int W     = 35,
    parameter int STEPS = 16
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [WIN-1:0] y_in,
    input  logic signed [WIN-1:0] x_in,
    output logic signed [ZW-1:0]  angle
);

    logic signed [W-1:0]  xe, ye, x_next, y_next, x0_reg, y0_reg;
    logic signed [ZW-1:0] z_next, z0_reg;
    logic                 zero_next, zero0_reg;

    logic signed [W-1:0]  x_c [0:STEPS];
    logic signed [W-1:0]  y_c [0:STEPS];
    logic signed [ZW-1:0] z_c [0:STEPS];
    logic                 zero_c [0:STEPS];

    // fold the left half plane onto the right one
    always_comb
    begin
        xe     = W'(x_in);
        ye     = W'(y_in);
        z_next = '0;
        if (x_in < 0)
        begin
            z_next = (y_in >= 0) ? DEG180_INT : -DEG180_INT;
            xe     = -xe;
            ye     = -ye;
        end
        x_next    = xe <<< PRESCALE_SH;
        y_next    = ye <<< PRESCALE_SH;
        zero_next = (x_in == 0) && (y_in == 0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg    <= x_next;
            y0_reg    <= y_next;
            z0_reg    <= z_next;
            zero0_reg <= zero_next;
        end
    end

    assign x_c[0]    = x0_reg;
    assign y_c[0]    = y0_reg;
    assign z_c[0]    = z0_reg;
    assign zero_c[0] = zero0_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_cell
        scara_ik_cordic_cell #(.W(W), .STEP(k)) u_cell (
            .clk      (clk),
            .en       (en),
            .x_in     (x_c[k]),
            .y_in     (y_c[k]),
            .z_in     (z_c[k]),
            .zero_in  (zero_c[k]),
            .x_out    (x_c[k+1]),
            .y_out    (y_c[k+1]),
            .z_out    (z_c[k+1]),
            .zero_out (zero_c[k+1])
        );
    end

    // atan2 of the origin is zero
    assign angle = zero_c[STEPS] ? '0 : z_c[STEPS];

endmodule

/* rtl/scara_ik_acos.sv */
// Pipelined acos(num / sqrt(den2)) as atan2(isqrt(den2 - num^2), num).
// Depends on scara_ik_pkg, scara_ik_isqrt_cell, scara_ik_atan2.
module scara_ik_acos
    import scara_ik_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [NUMW-1:0] num,
    input  logic [DENW-1:0]        den2,
    output logic signed [ZW-1:0]   angle
);

    localparam int MAGW = NUMW - 2;
    localparam int N2W  = 2 * MAGW;

    logic [MAGW-1:0]        mag;
    logic [N2W-1:0]         n2_next, n2_reg, den_ext;
    logic [DENW-1:0]        den_a_reg, h2_next, h2_reg;
    logic signed [NUMW-1:0] num_a_reg, num_b_reg;
    logic signed [NUMW-1:0] num_d_reg [0:ISQ_STEPS-1];
    logic signed [NUMW-1:0] root;

    logic [SQW-1:0] v_c [0:ISQ_STEPS];
    logic [SQW-1:0] r_c [0:ISQ_STEPS];

    always_comb
    begin
        mag     = num[NUMW-1] ? MAGW'(-num) : MAGW'(num);
        n2_next = mag * mag;
        den_ext = N2W'(den_a_reg);
        // argument clamped to +-1
        h2_next = (den_ext > n2_reg) ? DENW'(den_ext - n2_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg    <= n2_next;
            den_a_reg <= den2;
            num_a_reg <= num;
            h2_reg    <= h2_next;
            num_b_reg <= num_a_reg;
            num_d_reg[0] <= num_b_reg;
            for (int k = 1; k < ISQ_STEPS; k++)
                num_d_reg[k] <= num_d_reg[k-1];
        end
    end

    assign v_c[0] = SQW'(h2_reg);
    assign r_c[0] = '0;

    for (genvar k = 0; k < ISQ_STEPS; k++)
    begin : g_root
        scara_ik_isqrt_cell #(.K(k)) u_cell (
            .clk   (clk),
            .en    (en),
            .v_in  (v_c[k]),
            .r_in  (r_c[k]),
            .v_out (v_c[k+1]),
            .r_out (r_c[k+1])
        );
    end

    assign root = signed'(NUMW'(r_c[ISQ_STEPS]));

    scara_ik_atan2 #(.WIN(NUMW), .W(NUMW + CORDIC_GUARD), .STEPS(STEPS)) u_atan (
        .clk   (clk),
        .en    (en),
        .y_in  (root),
        .x_in  (num_d_reg[ISQ_STEPS-1]),
        .angle (angle)
    );

endmodule

/* rtl/scara_inverse_kinematics_core.sv */
// Top level of the RRPR SCARA inverse kinematics core.
// Depends on scara_ik_pkg, scara_ik_atan2, scara_ik_acos and the assert header.
//
//   channel  | handshake          | word
//   ---------+--------------------+-------------------------------------------
//   cfg      | cfg_we             | cfg_index, cfg_wdata (8 registers)
//   in       | in_valid/in_stall  | target x, y, z, phi + current joints
//   out      | out_valid/out_stall| joint angles, slide, found, chosen_branch
//
// One word per cycle is taken unless stalled. The depth is set by the acos path:
// input, square, numerator, denominator, acos square and acos difference stages,
// 29 root cells and a 1 + CORDIC_STEPS cell atan2 row, plus five decision stages.
// All stages advance together; a stalled result holds the whole row of cells
// and in_stall follows. Reset clears the valid bits and loads register defaults.
`include "scara_inverse_kinematics_core_assert.svh"
module scara_inverse_kinematics_core
    import scara_ik_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic signed [15:0] target_z,
    input  logic signed [15:0] target_phi,
    input  logic signed [14:0] current_joint1,
    input  logic signed [14:0] current_joint2,
    input  logic signed [13:0] current_slide,
    input  logic signed [14:0] current_joint4,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] joint1_angle,
    output logic signed [14:0] joint2_angle,
    output logic signed [15:0] slide_position,
    output logic signed [14:0] joint4_angle,
    output logic               found,
    output logic               chosen_branch
);

    // timing: t0 = input registers; acos results ready at T_A
    localparam int ACOS_LAT = 3 + ISQ_STEPS + CORDIC_STEPS;
    localparam int T_A      = 3 + ACOS_LAT;
    localparam int D_XY     = T_A - 1 - CORDIC_STEPS;
    localparam int D_FLAG   = T_A - 2;
    localparam int PIPE_LEN = T_A + 6;

    // ---------------- configuration registers ----------------
    logic [12:0]        upper_link_length_reg, lower_link_length_reg;
    logic signed [15:0] height_offset_reg;
    logic [13:0]        joint1_limit_reg, joint2_limit_reg, joint4_limit_reg;
    logic signed [13:0] slide_low_limit_reg, slide_high_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_link_length_reg <= 13'd3120;
            lower_link_length_reg <= 13'd2272;
            height_offset_reg     <= -16'sd1200;
            joint1_limit_reg      <= 14'd9600;
            joint2_limit_reg      <= 14'd6400;
            slide_low_limit_reg   <= -14'sd3200;
            slide_high_limit_reg  <= -14'sd1600;
            joint4_limit_reg      <= 14'd10240;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UPPER_LINK: upper_link_length_reg <= cfg_wdata[12:0];
                REG_LOWER_LINK: lower_link_length_reg <= cfg_wdata[12:0];
                REG_HEIGHT_OFS: height_offset_reg     <= signed'(cfg_wdata);
                REG_J1_LIMIT:   joint1_limit_reg      <= cfg_wdata[13:0];
                REG_J2_LIMIT:   joint2_limit_reg      <= cfg_wdata[13:0];
                REG_SLIDE_LOW:  slide_low_limit_reg   <= signed'(cfg_wdata[13:0]);
                REG_SLIDE_HIGH: slide_high_limit_reg  <= signed'(cfg_wdata[13:0]);
                REG_J4_LIMIT:   joint4_limit_reg      <= cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic vld_reg [0:PIPE_LEN-1];
    logic en;

    // the row moves unless a finished word is held at the output
    assign en        = !vld_reg[PIPE_LEN-1] || !out_stall;
    assign in_stall  = !en;
    assign out_valid = vld_reg[PIPE_LEN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_LEN; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < PIPE_LEN; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ---------------- t0: input word ----------------
    logic signed [15:0] x_reg, y_reg;
    side_t              side_next, side0_reg;

    always_comb
    begin
        side_next.z         = target_z;
        side_next.phi       = target_phi;
        side_next.cur_j1    = current_joint1;
        side_next.cur_j2    = current_joint2;
        side_next.cur_slide = current_slide;
        side_next.cur_j4    = current_joint4;
    end

    // ---------------- t1: squares ----------------
    logic [31:0] xx_next, yy_next, xx_reg, yy_reg;
    logic [25:0] a2_next, b2_next, a2_reg, b2_reg;
    logic [27:0] reach2_next, reach2_reg;

    assign xx_next     = unsigned'(32'(x_reg * x_reg));
    assign yy_next     = unsigned'(32'(y_reg * y_reg));
    assign a2_next     = upper_link_length_reg * upper_link_length_reg;
    assign b2_next     = lower_link_length_reg * lower_link_length_reg;
    assign reach2_next = (28'(upper_link_length_reg) + 28'(lower_link_length_reg))
                       * (28'(upper_link_length_reg) + 28'(lower_link_length_reg));

    // ---------------- t2: reach, acos numerators ----------------
    logic [31:0]            r2;
    logic signed [33:0]     num_off_w, num_el_w;
    reach_flags_t           flags_next, flags_reg;
    logic signed [NUMW-1:0] num_off_reg, num_el_reg;
    logic [27:0]            r2_lo_reg;
    logic [25:0]            a2_2_reg, b2_2_reg;

    always_comb
    begin
        r2 = xx_reg + yy_reg;
        flags_next.in_range = (r2 < 32'(reach2_reg)) && (upper_link_length_reg != '0)
                              && (lower_link_length_reg != '0);
        flags_next.r2_nz    = (r2 != '0);
        num_off_w = signed'(34'(a2_reg)) + signed'(34'(r2)) - signed'(34'(b2_reg));
        num_el_w  = signed'(34'(a2_reg)) + signed'(34'(b2_reg)) - signed'(34'(r2));
    end

    // ---------------- t3: squared denominators ----------------
    logic [53:0]            prod_off;
    logic [51:0]            prod_el;
    logic [DENW-1:0]        den_off_reg, den_el_reg;
    logic signed [NUMW-1:0] num_off3_reg, num_el3_reg;

    assign prod_off = a2_2_reg * r2_lo_reg;
    assign prod_el  = a2_2_reg * b2_2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg        <= target_x;
            y_reg        <= target_y;
            side0_reg    <= side_next;
            xx_reg       <= xx_next;
            yy_reg       <= yy_next;
            a2_reg       <= a2_next;
            b2_reg       <= b2_next;
            reach2_reg   <= reach2_next;
            flags_reg    <= flags_next;
            num_off_reg  <= NUMW'(num_off_w);
            num_el_reg   <= NUMW'(num_el_w);
            r2_lo_reg    <= r2[27:0];
            a2_2_reg     <= a2_reg;
            b2_2_reg     <= b2_reg;
            den_off_reg  <= {prod_off, 2'b00};
            den_el_reg   <= {2'b00, prod_el, 2'b00};
            num_off3_reg <= num_off_reg;
            num_el3_reg  <= num_el_reg;
        end
    end

    // ---------------- CORDIC rows ----------------
    logic signed [ZW-1:0] xy_raw, off_raw, el_raw;

    scara_ik_atan2 #(.WIN(16), .W(16 + CORDIC_GUARD), .STEPS(CORDIC_STEPS)) u_atan_xy (
        .clk   (clk),
        .en    (en),
        .y_in  (y_reg),
        .x_in  (x_reg),
        .angle (xy_raw)
    );

    scara_ik_acos #(.STEPS(CORDIC_STEPS)) u_acos_off (
        .clk   (clk),
        .en    (en),
        .num   (num_off3_reg),
        .den2  (den_off_reg),
        .angle (off_raw)
    );

    scara_ik_acos #(.STEPS(CORDIC_STEPS)) u_acos_el (
        .clk   (clk),
        .en    (en),
        .num   (num_el3_reg),
        .den2  (den_el_reg),
        .angle (el_raw)
    );

    // alignment lines up to T_A
    logic signed [ZW-1:0] xy_dly_reg [0:D_XY-1];
    reach_flags_t         flag_dly_reg [0:D_FLAG-1];
    side_t                side_dly_reg [0:T_A-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xy_dly_reg[0]   <= xy_raw;
            flag_dly_reg[0] <= flags_reg;
            side_dly_reg[0] <= side0_reg;
            for (int k = 1; k < D_XY; k++)
                xy_dly_reg[k] <= xy_dly_reg[k-1];
            for (int k = 1; k < D_FLAG; k++)
                flag_dly_reg[k] <= flag_dly_reg[k-1];
            for (int k = 1; k < T_A; k++)
                side_dly_reg[k] <= side_dly_reg[k-1];
        end
    end

    // ---------------- helpers ----------------
    function automatic logic signed [OW-1:0] round_out(input logic signed [IW-1:0] v);
        logic signed [IW-1:0] t;
        t = v + ROUND_BIAS;
        return OW'(t >>> ROUND_SH);
    endfunction

    function automatic logic signed [OW-1:0] wrap_once(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] r;
        r = v;
        if (v < -DEG180_OUT)
            r = v + DEG360_OUT;
        else if (v > DEG180_OUT)
            r = v - DEG360_OUT;
        return r;
    endfunction

    function automatic logic [SCW-1:0] abs_sc(input logic signed [SCW-1:0] v);
        return v[SCW-1] ? unsigned'(SCW'(-v)) : unsigned'(v);
    endfunction

    function automatic logic [OW-1:0] abs_ow(input logic signed [OW-1:0] v);
        return v[OW-1] ? unsigned'(OW'(-v)) : unsigned'(v);
    endfunction

    // exclusive limits on all four joints
    function automatic logic in_limits(input sol_t s);
        logic ok;
        ok = (abs_ow(s.j1) < OW'(joint1_limit_reg))
          && (abs_ow(s.j2) < OW'(joint2_limit_reg))
          && (abs_ow(s.j4) < OW'(joint4_limit_reg))
          && (s.slide < SLW'(slide_high_limit_reg))
          && (s.slide > SLW'(slide_low_limit_reg));
        return ok;
    endfunction

    function automatic logic [SCW-1:0] max2(input logic [SCW-1:0] p, input logic [SCW-1:0] q);
        return (q > p) ? q : p;
    endfunction

    // ---------------- F1: offset/elbow gating, angle sums ----------------
    reach_flags_t         fl;
    side_t                sd;
    logic signed [IW-1:0] xy_e, off_e, el_e, phi_e;
    logic signed [IW-1:0] j1a_next, j1b_next, el_next, j4a_next, j4b_next;
    logic signed [IW-1:0] j1a_reg, j1b_reg, el_reg, j4a_reg, j4b_reg;
    logic signed [SLW-1:0] slide_next, slide_f1_reg;
    side_t                side_f1_reg;

    always_comb
    begin
        fl    = flag_dly_reg[D_FLAG-1];
        sd    = side_dly_reg[T_A-1];
        xy_e  = IW'(xy_dly_reg[D_XY-1]);
        off_e = (fl.in_range && fl.r2_nz) ? IW'(off_raw) : '0;
        el_e  = fl.in_range ? IW'(DEG180_INT - el_raw) : '0;
        phi_e = IW'(sd.phi) <<< ROUND_SH;
        j1a_next = xy_e - off_e;
        j1b_next = xy_e + off_e;
        el_next  = el_e;
        j4a_next = xy_e - off_e + el_e - phi_e;
        j4b_next = xy_e + off_e - el_e - phi_e;
        slide_next = SLW'(height_offset_reg) - SLW'(sd.z);
    end

    // ---------------- F2: round and wrap ----------------
    sol_t s1_next, s2_next, s1_f2_reg, s2_f2_reg;
    side_t side_f2_reg;

    always_comb
    begin
        s1_next.j1    = wrap_once(round_out(j1a_reg));
        s2_next.j1    = wrap_once(round_out(j1b_reg));
        s1_next.j2    = round_out(el_reg);
        s2_next.j2    = round_out(-el_reg);
        s1_next.slide = slide_f1_reg;
        s2_next.slide = slide_f1_reg;
        s1_next.j4    = wrap_once(round_out(j4a_reg));
        s2_next.j4    = wrap_once(round_out(j4b_reg));
    end

    // ---------------- F3: limits and per-joint changes ----------------
    logic           v1_next, v2_next, v1_f3_reg, v2_f3_reg;
    logic [SCW-1:0] d1_next [0:3];
    logic [SCW-1:0] d2_next [0:3];
    logic [SCW-1:0] d1_reg  [0:3];
    logic [SCW-1:0] d2_reg  [0:3];
    sol_t           s1_f3_reg, s2_f3_reg;

    always_comb
    begin
        v1_next = in_limits(s1_f2_reg);
        v2_next = in_limits(s2_f2_reg);
        d1_next[0] = abs_sc(SCW'(side_f2_reg.cur_j1) - SCW'(s1_f2_reg.j1));
        d1_next[1] = abs_sc(SCW'(side_f2_reg.cur_j2) - SCW'(s1_f2_reg.j2));
        d1_next[2] = abs_sc(SCW'(side_f2_reg.cur_slide) - SCW'(s1_f2_reg.slide)) << 2;
        d1_next[3] = abs_sc(SCW'(side_f2_reg.cur_j4) - SCW'(s1_f2_reg.j4));
        d2_next[0] = abs_sc(SCW'(side_f2_reg.cur_j1) - SCW'(s2_f2_reg.j1));
        d2_next[1] = abs_sc(SCW'(side_f2_reg.cur_j2) - SCW'(s2_f2_reg.j2));
        d2_next[2] = abs_sc(SCW'(side_f2_reg.cur_slide) - SCW'(s2_f2_reg.slide)) << 2;
        d2_next[3] = abs_sc(SCW'(side_f2_reg.cur_j4) - SCW'(s2_f2_reg.j4));
    end

    // ---------------- F4: scores ----------------
    logic [SCW-1:0] sc1_next, sc2_next, sc1_reg, sc2_reg;
    logic           v1_f4_reg, v2_f4_reg;
    sol_t           s1_f4_reg, s2_f4_reg;

    assign sc1_next = max2(max2(d1_reg[0], d1_reg[1]), max2(d1_reg[2], d1_reg[3]));
    assign sc2_next = max2(max2(d2_reg[0], d2_reg[1]), max2(d2_reg[2], d2_reg[3]));

    // ---------------- F5: pick, output word ----------------
    sol_t pick;
    logic found_next, branch_next;
    logic signed [14:0] j1_out_reg, j2_out_reg, j4_out_reg;
    logic signed [15:0] slide_out_reg;
    logic               found_reg, branch_reg;

    always_comb
    begin
        pick        = '0;
        found_next  = 1'b1;
        branch_next = 1'b0;
        if (v1_f4_reg && v2_f4_reg)
        begin
            // a tie goes to the second solution
            if (sc1_reg < sc2_reg)
                pick = s1_f4_reg;
            else
            begin
                pick        = s2_f4_reg;
                branch_next = 1'b1;
            end
        end
        else if (v1_f4_reg)
            pick = s1_f4_reg;
        else if (v2_f4_reg)
        begin
            pick        = s2_f4_reg;
            branch_next = 1'b1;
        end
        else
            found_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j1a_reg      <= j1a_next;
            j1b_reg      <= j1b_next;
            el_reg       <= el_next;
            j4a_reg      <= j4a_next;
            j4b_reg      <= j4b_next;
            slide_f1_reg <= slide_next;
            side_f1_reg  <= sd;
            s1_f2_reg    <= s1_next;
            s2_f2_reg    <= s2_next;
            side_f2_reg  <= side_f1_reg;
            v1_f3_reg    <= v1_next;
            v2_f3_reg    <= v2_next;
            s1_f3_reg    <= s1_f2_reg;
            s2_f3_reg    <= s2_f2_reg;
            for (int k = 0; k < 4; k++)
            begin
                d1_reg[k] <= d1_next[k];
                d2_reg[k] <= d2_next[k];
            end
            sc1_reg       <= sc1_next;
            sc2_reg       <= sc2_next;
            v1_f4_reg     <= v1_f3_reg;
            v2_f4_reg     <= v2_f3_reg;
            s1_f4_reg     <= s1_f3_reg;
            s2_f4_reg     <= s2_f3_reg;
            j1_out_reg    <= pick.j1[14:0];
            j2_out_reg    <= pick.j2[14:0];
            slide_out_reg <= pick.slide[15:0];
            j4_out_reg    <= pick.j4[14:0];
            found_reg     <= found_next;
            branch_reg    <= branch_next;
        end
    end

    assign joint1_angle   = j1_out_reg;
    assign joint2_angle   = j2_out_reg;
    assign slide_position = slide_out_reg;
    assign joint4_angle   = j4_out_reg;
    assign found          = found_reg;
    assign chosen_branch  = branch_reg;

    // ---------------- checks ----------------
    logic signed [14:0] j2_lim_s;
    logic               out_j2_ok;

    assign j2_lim_s  = signed'({1'b0, joint2_limit_reg});
    assign out_j2_ok = (joint2_angle < j2_lim_s) && (joint2_angle > -j2_lim_s);

    // no solution gives an all-zero word
    `SIK_ASSERT_IMPLY(a_nofind_zero, out_valid && !found,
        joint1_angle == 0 && joint2_angle == 0 && slide_position == 0 &&
        joint4_angle == 0 && !chosen_branch)
    // a held result freezes the input side
    `SIK_ASSERT_IMPLY(a_hold_stalls_in, out_valid && out_stall, in_stall)
    // the last decision stage reaches the output when the row moves
    `SIK_ASSERT_NEXT(a_last_stage_out, en && vld_reg[PIPE_LEN-2], out_valid)
    // a reported solution respects the elbow limit
    `SIK_ASSERT_IMPLY(a_found_in_limit, out_valid && found, out_j2_ok)

endmodule
